// File: hdl/gcw_pkg.sv
// Shared types and constants for the gilbert curve walker.
// No dependencies; imported by the core and its checker.
package gcw_pkg;

    localparam int GCW_MAX_DIM     = 1024;
    localparam int GCW_STACK_DEPTH = 32;
    localparam int GCW_CFG_W       = 11;
    localparam int GCW_PHASE_W     = 3;

    // register index as decoded from paddr[2]
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic [GCW_PHASE_W-1:0] PH_0 = 3'd0;
    localparam logic [GCW_PHASE_W-1:0] PH_1 = 3'd1;
    localparam logic [GCW_PHASE_W-1:0] PH_2 = 3'd2;
    localparam logic [GCW_PHASE_W-1:0] PH_3 = 3'd3;
    localparam logic [GCW_PHASE_W-1:0] PH_4 = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_PUSH,
        ST_OUT
    } t_state;

endpackage

// File: hdl/gilbert_curve_2d_walker_core.sv
// Gilbert curve walker core: frame stack in a synchronous RAM, sequencer.
// Depends on gcw_pkg.
//
// channel   | dir | fields (low bit first)
// s_axis    | in  | tdata: restart
// m_axis    | out | tdata: cell_x, cell_y, curve_index; tlast: last_cell; tuser: exhausted
// apb       | cfg | 0x0 grid_width, 0x4 grid_height
//
// Restart and exhausted requests pass through accept and output load.
// An advance passes through accept, frame read, evaluate and output load, with a push step per frame
// push and a read and evaluate per frame pop; each stack step is one frame RAM read plus an evaluate.
// Reset is synchronous and needs no clearing pass; the walk starts ended.
// A stalled output holds the sequencer in ST_OUT; one request at a time.
module gilbert_curve_2d_walker_core
    import gcw_pkg::*;
#(
    parameter int MAX_DIM     = GCW_MAX_DIM,
    parameter int STACK_DEPTH = GCW_STACK_DEPTH,
    localparam int CW   = $clog2(MAX_DIM),
    localparam int SW   = 2 * CW,
    localparam int ODW  = ((2 * CW + SW + 7) / 8) * 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [7:0]     s_axis_tdata,   // [0] restart
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [ODW-1:0] m_axis_tdata,   // cell_x, cell_y, curve_index, zero pad
    output logic           m_axis_tlast,   // last_cell
    output logic           m_axis_tuser,   // exhausted
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int DIMW = CW + 1;
    localparam int TW   = 2 * DIMW;
    localparam int DW   = CW + 2;
    localparam int FW   = 4 * DW + GCW_PHASE_W;
    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SPW  = $clog2(STACK_DEPTH + 1);

    function automatic logic [DIMW-1:0] f_eff(input logic [GCW_CFG_W-1:0] raw);
        logic [31:0] d;
        d = {{(32-GCW_CFG_W){1'b0}}, raw & ~GCW_CFG_W'(1)};
        if (d < 32'd2) d = 32'd2;
        if (d > 32'(MAX_DIM)) d = 32'(MAX_DIM);
        return d[DIMW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] f_half(input logic signed [DW-1:0] v);
        return (v + $signed(DW'(v < 0))) >>> 1;
    endfunction

    function automatic logic signed [1:0] f_sgn(input logic signed [DW-1:0] v);
        return (v == 0) ? 2'sd0 : ((v > 0) ? 2'sd1 : -2'sd1);
    endfunction

    function automatic logic signed [DW-1:0] f_abs(input logic signed [DW-1:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [FW-1:0] f_pack(input logic signed [DW-1:0] ax, ay, bx, by,
                                             input logic [GCW_PHASE_W-1:0] ph);
        return {ax, ay, bx, by, ph};
    endfunction

    t_state r_state, n_state;

    logic [GCW_CFG_W-1:0] r_width, r_height;
    logic [CW-1:0]        r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic [SW-1:0]        r_step, n_step;
    logic [SPW-1:0]       r_sp, n_sp;
    logic [CW-1:0]        r_seg, n_seg;
    logic                 r_done, n_done;
    logic                 r_exh, n_exh;
    logic [FW-1:0]        r_child, n_child;

    logic                 r_ovalid;
    logic [ODW-1:0]       r_odata;
    logic                 r_olast, r_oexh;

    logic [FW-1:0]        r_mem [STACK_DEPTH];
    logic [FW-1:0]        r_rdata;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr, rd_addr;
    logic [FW-1:0]        mem_wdata;
    logic [SPW-1:0]       sp_m1;

    logic [DIMW-1:0]      eff_w, eff_h;
    logic [TW-1:0]        total;
    logic                 cfg_wr, in_acc, out_load;

    logic signed [DW-1:0] ax, ay, bx, by, ax1, ay1, bx1, by1, ax2, ay2, bx2, by2;
    logic signed [DW-1:0] ww, hh, lenv, sa1, sb1;
    logic signed [1:0]    dax, day, dbx, dby, mv_x, mv_y;
    logic [GCW_PHASE_W-1:0] ph;
    logic [TW-1:0]        step_inc;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_GRID_HEIGHT) ? {21'b0, r_height} : {21'b0, r_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= GCW_CFG_W'(16);
            r_height <= GCW_CFG_W'(16);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_GRID_WIDTH) r_width <= pwdata[GCW_CFG_W-1:0];
            else                            r_height <= pwdata[GCW_CFG_W-1:0];
        end
    end

    assign eff_w = f_eff(r_width);
    assign eff_h = f_eff(r_height);
    assign total = TW'(eff_w) * TW'(eff_h);

    // frame RAM
    assign sp_m1   = r_sp - SPW'(1);
    assign rd_addr = sp_m1[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[rd_addr];
    end

    // frame decode
    always_comb begin
        {ax, ay, bx, by, ph} = r_rdata;
        ww  = f_abs(ax + ay);
        hh  = f_abs(bx + by);
        dax = f_sgn(ax);
        day = f_sgn(ay);
        dbx = f_sgn(bx);
        dby = f_sgn(by);
        ax1 = f_half(ax);
        ay1 = f_half(ay);
        bx1 = f_half(bx);
        by1 = f_half(by);
        sa1 = ax1 + ay1;
        sb1 = bx1 + by1;
        if (sa1[0] && ww > DW'(2)) begin
            ax1 = ax1 + DW'(dax);
            ay1 = ay1 + DW'(day);
        end
        if (sb1[0] && hh > DW'(2)) begin
            bx1 = bx1 + DW'(dbx);
            by1 = by1 + DW'(dby);
        end
        ax2  = ax - ax1;
        ay2  = ay - ay1;
        bx2  = bx - bx1;
        by2  = by - by1;
        lenv = (hh == DW'(1)) ? ww : hh;
    end

    assign in_acc   = s_axis_tvalid & s_axis_tready;
    assign out_load = (r_state == ST_OUT) && (!r_ovalid || m_axis_tready);
    assign s_axis_tready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_step  <= '0;
            r_sp    <= '0;
            r_seg   <= '0;
            r_done  <= 1'b1;
            r_exh   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_step  <= n_step;
            r_sp    <= n_sp;
            r_seg   <= n_seg;
            r_done  <= n_done;
            r_exh   <= n_exh;
        end
        r_child <= n_child;
    end

    always_comb begin
        n_state   = r_state;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_step    = r_step;
        n_sp      = r_sp;
        n_seg     = r_seg;
        n_done    = r_done | cfg_wr;
        n_exh     = r_exh;
        n_child   = r_child;
        mem_we    = 1'b0;
        mem_waddr = rd_addr;
        mem_wdata = f_pack(ax, ay, bx, by, ph + GCW_PHASE_W'(1));
        mv_x      = 2'sd0;
        mv_y      = 2'sd0;
        step_inc  = TW'(r_step) + TW'(1);

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_exh = 1'b0;
                    if (s_axis_tdata[0]) begin
                        n_pos_x   = '0;
                        n_pos_y   = '0;
                        n_step    = '0;
                        n_seg     = '0;
                        n_done    = 1'b0;
                        n_sp      = SPW'(1);
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        if (eff_w >= eff_h)
                            mem_wdata = f_pack(DW'(eff_w), '0, '0, DW'(eff_h), PH_0);
                        else
                            mem_wdata = f_pack('0, DW'(eff_h), DW'(eff_w), '0, PH_0);
                        n_state = ST_OUT;
                    end else if (r_done) begin
                        n_exh   = 1'b1;
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (r_sp == '0) begin
                    // curve ran out before the last index
                    n_done  = 1'b1;
                    n_exh   = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_READ;
                if (ww == DW'(2) && hh == DW'(2)) begin
                    case (ph)
                        PH_0: begin mv_x = dbx; mv_y = dby; n_state = ST_OUT; end
                        PH_1: begin mv_x = dax; mv_y = day; n_state = ST_OUT; end
                        PH_2: begin mv_x = -dbx; mv_y = -dby; n_state = ST_OUT; end
                        default: n_sp = sp_m1;
                    endcase
                    mem_we = (n_state == ST_OUT);
                end else if (hh == DW'(1) || ww == DW'(1)) begin
                    if ((DW+1)'(r_seg) + (DW+1)'(1) < (DW+1)'(lenv)) begin
                        n_seg = r_seg + CW'(1);
                        if (hh == DW'(1)) begin mv_x = dax; mv_y = day; end
                        else begin mv_x = dbx; mv_y = dby; end
                        n_state = ST_OUT;
                    end else begin
                        n_sp = sp_m1;
                    end
                end else begin
                    mem_we = 1'b1;
                    if ((DW+2)'(ww) * (DW+2)'(2) > (DW+2)'(hh) * (DW+2)'(3)) begin
                        case (ph)
                            PH_0: begin n_child = f_pack(ax1, ay1, bx, by, PH_0);
                                        n_state = ST_PUSH; end
                            PH_1: begin mv_x = dax; mv_y = day; n_state = ST_OUT; end
                            PH_2: begin n_child = f_pack(ax2, ay2, bx, by, PH_0);
                                        n_state = ST_PUSH; end
                            default: begin mem_we = 1'b0; n_sp = sp_m1; end
                        endcase
                    end else begin
                        case (ph)
                            PH_0: begin n_child = f_pack(bx1, by1, ax1, ay1, PH_0);
                                        n_state = ST_PUSH; end
                            PH_1: begin mv_x = dbx; mv_y = dby; n_state = ST_OUT; end
                            PH_2: begin n_child = f_pack(ax, ay, bx2, by2, PH_0);
                                        n_state = ST_PUSH; end
                            PH_3: begin mv_x = -dbx; mv_y = -dby; n_state = ST_OUT; end
                            PH_4: begin n_child = f_pack(-bx1, -by1, -ax2, -ay2, PH_0);
                                        n_state = ST_PUSH; end
                            default: begin mem_we = 1'b0; n_sp = sp_m1; end
                        endcase
                    end
                end
                if (n_state == ST_OUT) begin
                    n_pos_x = r_pos_x + CW'(mv_x);
                    n_pos_y = r_pos_y + CW'(mv_y);
                    n_step  = step_inc[SW-1:0];
                    if (TW'(n_step) + TW'(1) >= total) n_done = 1'b1;
                end
            end
            ST_PUSH: begin
                // drop the child when the stack is full
                if (r_sp < SPW'(STACK_DEPTH)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_sp[AW-1:0];
                    mem_wdata = r_child;
                    n_sp      = r_sp + SPW'(1);
                    n_seg     = '0;
                end
                n_state = ST_READ;
            end
            ST_OUT: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (out_load) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
        if (out_load) begin
            r_odata <= ODW'({r_step, r_pos_y, r_pos_x});
            r_olast <= (step_inc == total);
            r_oexh  <= r_exh;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_oexh;

endmodule

// File: hdl/gcw_checker.sv
// Port-level checks for the gilbert curve walker core, bound to the core.
// Depends on gcw_pkg.
module gcw_checker
    import gcw_pkg::*;
#(
    parameter int MAX_DIM = GCW_MAX_DIM,
    localparam int CW  = $clog2(MAX_DIM),
    localparam int ODW = ((4 * CW + 7) / 8) * 8
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           s_axis_tvalid,
    input logic           s_axis_tready,
    input logic           m_axis_tvalid,
    input logic           m_axis_tready,
    input logic [ODW-1:0] m_axis_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one request in flight at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // curve index zero is the origin
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4*CW-1:2*CW] == '0 |->
            m_axis_tdata[2*CW-1:0] == '0)
        else $error("index zero off origin");

endmodule

bind gilbert_curve_2d_walker_core gcw_checker #(.MAX_DIM(MAX_DIM)) u_gcw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
